// ===== sv/cwpg_pkg.sv =====
// Shared types, constants and tables for the colour wheel pixel generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cwpg_pkg;

    localparam int MAX_RADIUS_DEF = 255;
    localparam int FRAC_BITS_DEF  = 16;

    // Coordinate and squared-radius widths follow from the 9-bit fields.
    localparam int COORD_W   = 9;
    localparam int CRD_W     = 11;
    localparam int R2_W      = 19;
    localparam int CRD_PAIRS = 11;
    localparam int RW_W      = 8;
    localparam int INT_W     = 8;
    localparam int MODE_W    = 3;
    localparam int ERR_W     = 16;
    localparam int GREY_CORE = 5;

    localparam int ANG_Q        = 30;
    localparam int CORDIC_STEPS = 26;
    localparam int CX_W         = 44;
    localparam int Z_W          = 35;
    localparam int LOOP_W       = 6;

    // Reciprocal of 255 scaled by 2^32, rounded down.
    localparam int U_W   = 26;
    localparam int RCP_W = 25;
    localparam logic [RCP_W-1:0] RCP_255 = 25'd16843009;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTENSITY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 2'd2;

    localparam logic [MODE_W-1:0] MODE_INDEXED = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RGB555  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RGB565  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RGB888  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BGR888  = 3'd4;

    localparam logic [ERR_W-1:0] ERR_HALF = 16'h8000;

    typedef struct packed {
        logic              load;
        logic              prep;
        logic              chk;
        logic              step;
        logic [LOOP_W-1:0] idx;
        logic              dinit;
        logic              dstep;
        logic              wgt;
        logic              mul;
        logic              rcp;
        logic              fin;
    } cwpg_cmd_t;

    typedef struct packed {
        logic outside;
        logic out_free;
    } cwpg_sts_t;

    // Arctangent of 2^-i in Q30 units of pi/3.
    function automatic logic [30:0] cw_atan(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd805306368;
            5'd1:  v = 31'd475400108;
            5'd2:  v = 31'd251188361;
            5'd3:  v = 31'd127507134;
            5'd4:  v = 31'd64000997;
            5'd5:  v = 31'd32031698;
            5'd6:  v = 31'd16019758;
            5'd7:  v = 31'd8010367;
            5'd8:  v = 31'd4005245;
            5'd9:  v = 31'd2002630;
            5'd10: v = 31'd1001316;
            5'd11: v = 31'd500658;
            5'd12: v = 31'd250329;
            5'd13: v = 31'd125165;
            5'd14: v = 31'd62582;
            5'd15: v = 31'd31291;
            5'd16: v = 31'd15646;
            5'd17: v = 31'd7823;
            5'd18: v = 31'd3911;
            5'd19: v = 31'd1956;
            5'd20: v = 31'd978;
            5'd21: v = 31'd489;
            5'd22: v = 31'd244;
            5'd23: v = 31'd122;
            5'd24: v = 31'd61;
            5'd25: v = 31'd31;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/cwpg_ctrl.sv =====
// Sequencer for the colour wheel pixel generator.
// Depends on cwpg_pkg; drives the datapath through cwpg_cmd_t.
`timescale 1ns / 1ps

module cwpg_ctrl #(
    parameter int FRAC_BITS = cwpg_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cwpg_pkg::cwpg_sts_t sts,
    output cwpg_pkg::cwpg_cmd_t cmd
);
    import cwpg_pkg::*;

    localparam int RT_W   = CRD_PAIRS + FRAC_BITS;
    localparam int LOOP_N = (RT_W > CORDIC_STEPS) ? RT_W : CORDIC_STEPS;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PREP  = 10'b0000000010,
        ST_CHK   = 10'b0000000100,
        ST_ROOT  = 10'b0000001000,
        ST_DINIT = 10'b0000010000,
        ST_DIV   = 10'b0000100000,
        ST_WGT   = 10'b0001000000,
        ST_MUL   = 10'b0010000000,
        ST_RCP   = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [LOOP_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk    = 1'b1;
                cnt_next   = '0;
                state_next = sts.outside ? ST_FIN : ST_ROOT;
            end
            ST_ROOT: begin
                cmd.step = 1'b1;
                if (cnt_reg == LOOP_W'(LOOP_N - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DINIT: begin
                cmd.dinit  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.dstep = 1'b1;
                if (cnt_reg == LOOP_W'(RT_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_WGT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WGT: begin
                cmd.wgt    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_RCP;
            end
            ST_RCP: begin
                cmd.rcp    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // The result waits here until the output register is free.
                if (sts.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== sv/cwpg_dp.sv =====
// Datapath of the colour wheel pixel generator: config registers, square root,
// CORDIC angle, divider, colour weights, dither state and output register.
// Depends on cwpg_pkg; controlled by cwpg_ctrl.
`timescale 1ns / 1ps

module cwpg_dp #(
    parameter int MAX_RADIUS = cwpg_pkg::MAX_RADIUS_DEF,
    parameter int FRAC_BITS  = cwpg_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cwpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [7:0]                        cfg_wdata,
    input  logic                              in_sof,
    input  logic [cwpg_pkg::COORD_W-1:0]      in_column,
    input  logic [cwpg_pkg::COORD_W-1:0]      in_row,
    input  cwpg_pkg::cwpg_cmd_t               cmd,
    output cwpg_pkg::cwpg_sts_t               sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata
);
    import cwpg_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int RT_W  = CRD_PAIRS + F;
    localparam int REM_W = RT_W + 2;
    localparam int A_W   = F + 4;
    localparam int D_W   = F + 5;
    localparam int W_W   = F + 1;
    localparam int P_W   = 2 * W_W;
    localparam int WI_W  = W_W + INT_W;
    localparam int ONE   = 1 << F;

    // Configuration registers.
    logic [RW_W-1:0]   radius_reg;
    logic [INT_W-1:0]  inten_reg;
    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 8'd64;
            inten_reg  <= 8'd255;
            mode_reg   <= MODE_INDEXED;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RADIUS:    radius_reg <= cfg_wdata;
                CFG_INTENSITY: inten_reg  <= cfg_wdata;
                CFG_MODE:      mode_reg   <= cfg_wdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [RW_W-1:0] rw;
    always_comb begin
        if (radius_reg < RW_W'(6)) begin
            rw = RW_W'(6);
        end else if (int'(radius_reg) > MAX_RADIUS) begin
            rw = RW_W'(MAX_RADIUS);
        end else begin
            rw = radius_reg;
        end
    end

    // Offsets and squared radius.
    logic signed [CRD_W-1:0]   x_reg, y_reg;
    logic [R2_W-1:0]           r2_reg;
    logic [2*RW_W-1:0]         rr_reg;
    logic                      inside_reg, centre_reg;
    logic signed [CRD_W-1:0]   x_in, y_in;
    logic [RW_W-1:0]           rw_m1;
    logic signed [2*CRD_W-1:0] xx, yy;

    assign rw_m1 = rw - 1'b1;
    assign x_in  = signed'({2'b00, in_column}) - signed'({3'b000, rw_m1});
    assign y_in  = signed'({2'b00, in_row}) - signed'({3'b000, rw_m1});
    assign xx    = x_reg * x_reg;
    assign yy    = y_reg * y_reg;
    assign sts.outside = (r2_reg > {3'b000, rr_reg});

    // Square root, one result bit per step.
    logic [2*RT_W-1:0] rad_reg;
    logic [RT_W-1:0]   root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W+1:0]  rem_sh, trial;
    logic              take;

    assign rem_sh = {rem_reg, rad_reg[2*RT_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    // CORDIC vectoring, one rotation per step.
    logic signed [CX_W-1:0] cx_reg, cy_reg, xs, ys;
    logic signed [Z_W-1:0]  cz_reg, at;
    logic signed [CRD_W-1:0] xn, yn;
    logic signed [CX_W-1:0]  x0, y0;

    assign xn = -x_reg;
    assign yn = -y_reg;
    assign xs = cx_reg >>> cmd.idx[4:0];
    assign ys = cy_reg >>> cmd.idx[4:0];
    assign at = signed'({{(Z_W-31){1'b0}}, cw_atan(cmd.idx[4:0])});

    always_comb begin
        if (xn < 0) begin
            x0 = {{(CX_W-CRD_W-ANG_Q){x_reg[CRD_W-1]}}, x_reg, {ANG_Q{1'b0}}};
            y0 = {{(CX_W-CRD_W-ANG_Q){yn[CRD_W-1]}}, yn, {ANG_Q{1'b0}}};
        end else begin
            x0 = {{(CX_W-CRD_W-ANG_Q){xn[CRD_W-1]}}, xn, {ANG_Q{1'b0}}};
            y0 = {{(CX_W-CRD_W-ANG_Q){y_reg[CRD_W-1]}}, y_reg, {ANG_Q{1'b0}}};
        end
    end

    // Divider for the saturation fraction.
    logic [RT_W-1:0] num_reg, q_reg;
    logic [RW_W-1:0] den_reg, drem_reg;
    logic [RW_W:0]   dr_sh;
    logic            dtake;

    assign dr_sh = {drem_reg, num_reg[RT_W-1]};
    assign dtake = (dr_sh >= {1'b0, den_reg});

    // Hue ramps and weights.
    function automatic logic [W_W-1:0] ramp(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] t;
        logic [W_W-1:0]        r;
        t = ((d < 0) ? -d : d) - D_W'(ONE);
        if (t < 0) begin
            r = '0;
        end else if (t > D_W'(ONE)) begin
            r = W_W'(ONE);
        end else begin
            r = t[W_W-1:0];
        end
        return r;
    endfunction

    logic signed [Z_W-1:0] a_full;
    logic signed [A_W-1:0] a;
    logic signed [D_W-1:0] a_d, p_d;
    logic [W_W-1:0]        f, t_r, t_g, t_b;
    logic [P_W-1:0]        pr_reg, pg_reg, pb_reg;
    logic [W_W-1:0]        w_r, w_g, w_b;
    logic [WI_W-1:0]       wr_reg, wg_reg, wb_reg;

    assign a_full = cz_reg >>> (ANG_Q - F);
    assign a      = centre_reg ? '0 : a_full[A_W-1:0];
    assign a_d    = D_W'(a);
    assign p_d    = (a < 0) ? a_d + D_W'(6 * ONE) : a_d;
    assign f      = (q_reg > RT_W'(ONE)) ? W_W'(ONE) : q_reg[W_W-1:0];
    assign t_r    = ramp(p_d - D_W'(3 * ONE));
    assign t_g    = ramp(a_d + D_W'(ONE));
    assign t_b    = ramp(a_d - D_W'(ONE));
    assign w_r    = W_W'(ONE) - W_W'(pr_reg >> F);
    assign w_g    = W_W'(ONE) - W_W'(pg_reg >> F);
    assign w_b    = W_W'(ONE) - W_W'(pb_reg >> F);

    // Palette levels: u = w*4*I*2^16 / 2^F, then u / 255 by reciprocal.
    localparam int UX_W = WI_W + 18;
    logic [U_W-1:0]           ur_reg, ug_reg, ub_reg;
    logic [U_W+RCP_W-1:0]     mr_reg, mg_reg, mb_reg;
    logic [UX_W-1:0]          ux_r, ux_g, ux_b;

    assign ux_r = {wr_reg, 18'b0} >> F;
    assign ux_g = {wg_reg, 18'b0} >> F;
    assign ux_b = {wb_reg, 18'b0} >> F;

    function automatic logic [18:0] div255(input logic [U_W-1:0] u,
                                           input logic [U_W+RCP_W-1:0] m);
        logic [18:0]    q0;
        logic [U_W:0]   r;
        q0 = m[U_W+RCP_W-1 -: 19];
        r  = {1'b0, u} - (({8'b0, q0} << 8) - {8'b0, q0});
        return (r >= (U_W+1)'(255)) ? q0 + 1'b1 : q0;
    endfunction

    function automatic logic [15:0] tcol(input logic [WI_W-1:0] wi);
        logic [WI_W+9:0] v;
        v = ({wi, 8'b0} + (WI_W+10)'(wi)) + (WI_W+10)'(ONE / 2);
        return 16'(v >> F);
    endfunction

    logic [ERR_W-1:0] er_reg, eg_reg, eb_reg;
    logic [19:0]      sr, sg, sb;
    logic [6:0]       pal;
    logic [15:0]      c_r, c_g, c_b;
    logic [23:0]      pix;

    assign sr  = {1'b0, div255(ur_reg, mr_reg)} + {4'b0, er_reg};
    assign sg  = {1'b0, div255(ug_reg, mg_reg)} + {4'b0, eg_reg};
    assign sb  = {1'b0, div255(ub_reg, mb_reg)} + {4'b0, eb_reg};
    assign pal = 7'(sr[18:16] * 5'd25) + 7'(sg[18:16] * 3'd5) + 7'(sb[18:16]);
    assign c_r = tcol(wr_reg);
    assign c_g = tcol(wg_reg);
    assign c_b = tcol(wb_reg);

    always_comb begin
        case (mode_reg)
            MODE_INDEXED: pix = {17'b0, pal};
            MODE_RGB555:  pix = {9'b0, c_r[15:11], c_g[15:11], c_b[15:11]};
            MODE_RGB565:  pix = {8'b0, c_r[15:11], c_g[15:10], c_b[15:11]};
            MODE_RGB888:  pix = {c_r[15:8], c_g[15:8], c_b[15:8]};
            MODE_BGR888:  pix = {c_b[15:8], c_g[15:8], c_r[15:8]};
            default:      pix = '0;
        endcase
    end

    // Output register.
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            er_reg       <= ERR_HALF;
            eg_reg       <= ERR_HALF;
            eb_reg       <= ERR_HALF;
        end else begin
            if (cmd.fin) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.load && in_sof) begin
                er_reg <= ERR_HALF;
                eg_reg <= ERR_HALF;
                eb_reg <= ERR_HALF;
            end else if (cmd.fin && inside_reg && mode_reg == MODE_INDEXED) begin
                er_reg <= sr[15:0];
                eg_reg <= sg[15:0];
                eb_reg <= sb[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
        if (cmd.prep) begin
            r2_reg <= xx[R2_W-1:0] + yy[R2_W-1:0];
            rr_reg <= rw * rw;
        end
        if (cmd.chk) begin
            inside_reg <= !sts.outside;
            centre_reg <= (x_reg == 0) && (y_reg == 0);
            rad_reg    <= {3'b000, r2_reg, {(2*F){1'b0}}};
            root_reg   <= '0;
            rem_reg    <= '0;
            cx_reg     <= x0;
            cy_reg     <= y0;
            if (xn < 0) begin
                cz_reg <= (y_reg >= 0) ? Z_W'(3) <<< ANG_Q : -(Z_W'(3) <<< ANG_Q);
            end else begin
                cz_reg <= '0;
            end
        end
        if (cmd.step) begin
            if (cmd.idx < LOOP_W'(RT_W)) begin
                rad_reg <= rad_reg << 2;
                if (take) begin
                    rem_reg  <= REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[RT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[RT_W-2:0], 1'b0};
                end
            end
            if (cmd.idx < LOOP_W'(CORDIC_STEPS)) begin
                if (cy_reg >= 0) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
            end
        end
        if (cmd.dinit) begin
            num_reg  <= (root_reg > RT_W'(GREY_CORE * ONE)) ?
                        root_reg - RT_W'(GREY_CORE * ONE) : '0;
            den_reg  <= rw - RW_W'(GREY_CORE);
            drem_reg <= '0;
            q_reg    <= '0;
        end
        if (cmd.dstep) begin
            num_reg  <= num_reg << 1;
            drem_reg <= dtake ? RW_W'(dr_sh - {1'b0, den_reg}) : dr_sh[RW_W-1:0];
            q_reg    <= {q_reg[RT_W-2:0], dtake};
        end
        if (cmd.wgt) begin
            pr_reg <= f * t_r;
            pg_reg <= f * t_g;
            pb_reg <= f * t_b;
        end
        if (cmd.mul) begin
            wr_reg <= w_r * inten_reg;
            wg_reg <= w_g * inten_reg;
            wb_reg <= w_b * inten_reg;
        end
        if (cmd.rcp) begin
            ur_reg <= ux_r[U_W-1:0];
            ug_reg <= ux_g[U_W-1:0];
            ub_reg <= ux_b[U_W-1:0];
            mr_reg <= ux_r[U_W-1:0] * RCP_255;
            mg_reg <= ux_g[U_W-1:0] * RCP_255;
            mb_reg <= ux_b[U_W-1:0] * RCP_255;
        end
        if (cmd.fin) begin
            m_tdata_reg <= {7'b0, (inside_reg ? pix : 24'b0), inside_reg};
        end
    end

endmodule

// ===== sv/colour_wheel_pixel_generator.sv =====
// Top level of the colour wheel pixel generator: sequencer plus datapath.
// Depends on cwpg_pkg, cwpg_ctrl and cwpg_dp.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid/s_tready    tdata column,row; tuser start_of_frame
//   m_       out        m_tvalid/m_tready    tdata inside_res,pixel_value
//   cfg_     in         cfg_we               cfg_addr index, cfg_wdata value
//
// An inside pixel runs load, prep, check, the square root/CORDIC steps, divider
// init, the divider steps, weight, multiply, reciprocal and finish; an outside
// pixel runs load, prep, check and finish. The bit-serial root and divider dominate.
// Reset is synchronous and active low; it restores the config defaults and
// sets the dither errors to one half. A stalled output holds the finished
// result while the next pixel is accepted and computed.
`timescale 1ns / 1ps

module colour_wheel_pixel_generator #(
    parameter int MAX_RADIUS = cwpg_pkg::MAX_RADIUS_DEF,
    parameter int FRAC_BITS  = cwpg_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,  // column[8:0], row[17:9]
    input  logic                            s_tuser,  // start_of_frame
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // inside_res[0], pixel_value[24:1]
    input  logic                            cfg_we,
    input  logic [cwpg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                      cfg_wdata
);
    import cwpg_pkg::*;

    cwpg_cmd_t cmd;
    cwpg_sts_t sts;

    cwpg_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cwpg_dp #(
        .MAX_RADIUS(MAX_RADIUS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .in_sof   (s_tuser),
        .in_column(s_tdata[8:0]),
        .in_row   (s_tdata[17:9]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/cwpg_checker.sv =====
// Checker for the colour wheel pixel generator: follows the pixel and result
// channels, predicts each result from its own copy of the block state and compares.
// Depends on cwpg_pkg.
`timescale 1ns / 1ps

module cwpg_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,
    input  logic                            cfg_we,
    input  logic [cwpg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                      cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    import cwpg_pkg::*;

    typedef struct packed {
        logic        in_circle;
        logic [23:0] pixel;
    } pixel_result_t;

    localparam longint ONE = 64'd65536;
    localparam longint ARCTAN_PI3[26] = '{
        805306368, 475400108, 251188361, 127507134, 64000997, 32031698,
        16019758, 8010367, 4005245, 2002630, 1001316, 500658,
        250329, 125165, 62582, 31291, 15646, 7823,
        3911, 1956, 978, 489, 244, 122, 61, 31
    };

    logic [7:0]        radius_reg;
    logic [7:0]        intensity_reg;
    logic [MODE_W-1:0] mode_reg;
    longint            dither_err[3];
    pixel_result_t     expected_pixels[$];

    assign pending = expected_pixels.size();

    function automatic longint clamp_ramp(longint d);
        longint t;
        t = (d < 0 ? -d : d) - ONE;
        if (t < 0) t = 0;
        if (t > ONE) t = ONE;
        return t;
    endfunction

    // Works out one pixel and advances the dither errors where indexed mode uses them.
    function automatic pixel_result_t render_pixel(logic sof, int col, int row);
        pixel_result_t res;
        longint rw, x, y, r2, s, rem, pair, f, a, p, bx, by, z, xs, ys;
        longint w[3];
        longint c[3];
        longint lev, sum;
        longint lvl[3];
        if (sof) begin
            for (int k = 0; k < 3; k++) dither_err[k] = 64'h8000;
        end
        rw = radius_reg;
        if (rw < 6) rw = 6;
        if (rw > 255) rw = 255;
        x = col - (rw - 1);
        y = row - (rw - 1);
        r2 = x * x + y * y;
        res = '0;
        if (r2 > rw * rw) return res;
        res.in_circle = 1'b1;

        // Bit-serial square root of r2 scaled by 2^16.
        s = 0;
        rem = 0;
        for (int q = 26; q >= 0; q--) begin
            pair = (q >= 16) ? ((r2 >> (2 * (q - 16))) & 3) : 0;
            rem = (rem << 2) | pair;
            if (rem >= ((s << 2) | 1)) begin
                rem = rem - ((s << 2) | 1);
                s = (s << 1) | 1;
            end else begin
                s = s << 1;
            end
        end
        if (s <= GREY_CORE * ONE) f = 0;
        else begin
            f = (s - GREY_CORE * ONE) / (rw - GREY_CORE);
            if (f > ONE) f = ONE;
        end

        if (x == 0 && y == 0) a = 0;
        else begin
            bx = (-x) <<< 30;
            by = y <<< 30;
            z = 0;
            if (bx < 0) begin
                z = (by >= 0) ? (64'sd3 <<< 30) : -(64'sd3 <<< 30);
                bx = -bx;
                by = -by;
            end
            for (int i = 0; i < 26; i++) begin
                xs = bx >>> i;
                ys = by >>> i;
                if (by >= 0) begin
                    bx = bx + ys; by = by - xs; z = z + ARCTAN_PI3[i];
                end else begin
                    bx = bx - ys; by = by + xs; z = z - ARCTAN_PI3[i];
                end
            end
            a = z >>> 14;
        end
        p = (a < 0) ? a + 6 * ONE : a;
        w[0] = ONE - ((f * clamp_ramp(p - 3 * ONE)) >>> 16);
        w[1] = ONE - ((f * clamp_ramp(a + ONE)) >>> 16);
        w[2] = ONE - ((f * clamp_ramp(a - ONE)) >>> 16);
        for (int k = 0; k < 3; k++)
            c[k] = (w[k] * 257 * intensity_reg + ONE / 2) >>> 16;

        case (mode_reg)
            MODE_INDEXED: begin
                for (int k = 0; k < 3; k++) begin
                    lev = ((w[k] * 4 * intensity_reg) <<< 16) / (255 * ONE);
                    sum = lev + dither_err[k];
                    dither_err[k] = sum & 64'hffff;
                    lvl[k] = sum >>> 16;
                end
                res.pixel = 24'((lvl[0] * 5 + lvl[1]) * 5 + lvl[2]);
            end
            MODE_RGB555: res.pixel = 24'(((c[0] & 'hf800) >> 1) | ((c[1] & 'hf800) >> 6)
                                       | ((c[2] & 'hf800) >> 11));
            MODE_RGB565: res.pixel = 24'((c[0] & 'hf800) | ((c[1] & 'hfc00) >> 5)
                                       | ((c[2] & 'hf800) >> 11));
            MODE_RGB888: res.pixel = 24'(((c[0] & 'hff00) << 8) | (c[1] & 'hff00)
                                       | ((c[2] & 'hff00) >> 8));
            MODE_BGR888: res.pixel = 24'(((c[0] & 'hff00) >> 8) | (c[1] & 'hff00)
                                       | ((c[2] & 'hff00) << 8));
            default:     res.pixel = '0;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint exp_val, longint got_val);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what,
                 exp_val, got_val);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pixel_result_t exp_res;
        if (!aresetn) begin
            radius_reg    <= 8'd64;
            intensity_reg <= 8'd255;
            mode_reg      <= MODE_INDEXED;
            for (int k = 0; k < 3; k++) dither_err[k] = 64'h8000;
            expected_pixels.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_RADIUS:    radius_reg <= cfg_wdata;
                    CFG_INTENSITY: intensity_reg <= cfg_wdata;
                    CFG_MODE:      mode_reg <= cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_pixels.push_back(render_pixel(s_tuser, s_tdata[8:0], s_tdata[17:9]));
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected result", 0, m_tdata);
                end else begin
                    exp_res = expected_pixels.pop_front();
                    if (m_tdata[0] !== exp_res.in_circle)
                        report_mismatch("inside flag", exp_res.in_circle, m_tdata[0]);
                    if (m_tdata[24:1] !== exp_res.pixel)
                        report_mismatch("pixel value", exp_res.pixel, m_tdata[24:1]);
                end
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the colour wheel pixel generator testbench: clock, reset, pixel and
// register stimulus, and the verdict. Depends on cwpg_pkg, cwpg_checker and the block.
`timescale 1ns / 1ps

module tb_top;
    import cwpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_RADIUS;
    logic [7:0]            cfg_wdata = '0;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles = 0;

    always #2 aclk = ~aclk;

    colour_wheel_pixel_generator i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata
    );

    cwpg_checker i_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata,
        .fail_count, .pending
    );

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_pixel(logic sof, int col, int row);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = sof;
        s_tdata  = {6'd0, 9'(row), 9'(col)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Waits until every accepted pixel's result has been checked, then idles before the next phase.
    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    initial begin
        int radius_set[12]    = '{3, 6, 255, 64, 0, 17, 6, 255, 40, 5, 100, 9};
        int intensity_set[12] = '{255, 0, 255, 128, 1, 200, 255, 77, 255, 0, 33, 170};
        int mode_set[12]      = '{MODE_INDEXED, MODE_RGB555, MODE_RGB565, MODE_RGB888,
                                  MODE_BGR888, 5, MODE_INDEXED, 7, MODE_RGB565,
                                  6, MODE_INDEXED, MODE_BGR888};
        int side;
        int col;
        int row;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed pixels at the reset settings: centre, axes, rim and far corner.
        send_pixel(1'b1, 63, 63);
        send_pixel(1'b0, 126, 63);
        send_pixel(1'b0, 0, 63);
        send_pixel(1'b0, 63, 0);
        send_pixel(1'b0, 63, 126);
        send_pixel(1'b0, 0, 0);
        send_pixel(1'b0, 511, 511);
        send_pixel(1'b0, 100, 20);
        send_pixel(1'b0, 20, 100);
        send_pixel(1'b0, 66, 65);
        send_pixel(1'b0, 68, 63);
        send_pixel(1'b1, 30, 90);
        send_pixel(1'b0, 127, 63);
        wait_drained();

        for (int set_i = 0; set_i < 12; set_i++) begin
            write_reg(CFG_RADIUS, 8'(radius_set[set_i]));
            write_reg(CFG_INTENSITY, 8'(intensity_set[set_i]));
            write_reg(CFG_MODE, 8'(mode_set[set_i]));
            case (set_i % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            side = (radius_set[set_i] < 6) ? 11 : 2 * radius_set[set_i] - 1;
            for (int n = 0; n < 115; n++) begin
                // Quiet stretches inside each phase.
                if (n == 60) begin send_idle_pct /= 4; recv_stall_pct /= 4; end
                if ($urandom_range(99) < 85) begin
                    col = $urandom_range(side - 1);
                    row = $urandom_range(side - 1);
                end else begin
                    col = $urandom_range(511);
                    row = $urandom_range(511);
                end
                send_pixel(n == 0 || $urandom_range(99) < 3, col, row);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
